[hdl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define AST_HOLD(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/alc_pkg.sv]
// shared types and constants of the array list with cursor
`default_nettype none
package alc_pkg;

	localparam int DEFAULT_DEPTH = 16;
	localparam int CNT_W = 5;
	localparam int DATA_W = 32;
	localparam int ACT_W = 4;
	localparam int ST_W = 2;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 4'd0,
		ACT_APPEND = 4'd1,
		ACT_REMOVE = 4'd2,
		ACT_START  = 4'd3,
		ACT_END    = 4'd4,
		ACT_PREV   = 4'd5,
		ACT_NEXT   = 4'd6,
		ACT_MOVE   = 4'd7,
		ACT_GET    = 4'd8,
		ACT_CLEAR  = 4'd9
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_POS = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_up;
		logic scan_dn;
		logic drain;
		logic put;
		logic post;
	} dp_cmd_t;

	typedef struct packed {
		logic is_ins;
		logic ins_ok;
		logic need_up;
		logic need_read;
		logic up_done;
		logic dn_done;
	} dp_sts_t;

endpackage
`default_nettype wire

[hdl/alc_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module alc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/alc_ctrl.sv]
// controller state machine of the array list with cursor
`default_nettype none
module alc_ctrl import alc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_UP,
		S_DN,
		S_DRAIN,
		S_PUT,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_EXEC:  cmd.exec = 1'b1;
			S_UP:    cmd.scan_up = 1'b1;
			S_DN:    cmd.scan_dn = 1'b1;
			S_DRAIN: cmd.drain = 1'b1;
			S_PUT:   cmd.put = 1'b1;
			S_FIN:   cmd.post = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.need_up) state_q <= S_UP;
					else if (sts.ins_ok) state_q <= S_PUT;
					else if (sts.need_read) state_q <= S_DN;
					else state_q <= S_FIN;
				end
				S_UP: begin
					if (sts.up_done) state_q <= S_DRAIN;
				end
				S_DN: begin
					if (sts.dn_done) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= sts.is_ins ? S_PUT : S_FIN;
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.post) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/alc_dp.sv]
// datapath of the array list with cursor: entry store, count, cursor, result
`default_nettype none
module alc_dp import alc_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_data,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [CNT_W-1:0]  position,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	output logic      [ST_W-1:0]   status,
	output logic      [DATA_W-1:0] read_value,
	output logic      [CNT_W-1:0]  length,
	output logic      [CNT_W-1:0]  cursor
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [31:0] DEPTH_V = 32'(DEPTH);

	action_t           act_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cur_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  wptr_q;
	logic              wr_q;
	logic              grab_q;
	status_t           res_st_q;
	logic [DATA_W-1:0] res_rd_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] read_value_q;
	logic [CNT_W-1:0]  length_q;
	logic [CNT_W-1:0]  cursor_q;

	logic              is_ins;
	logic              full;
	logic              ins_ok;
	logic              in_list;
	logic [CNT_W-1:0]  eff_cur;
	logic [CNT_W-1:0]  last_idx;
	status_t           nxt_st;
	logic [CNT_W-1:0]  nxt_cur;
	logic [CNT_W-1:0]  nxt_cnt;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	// decode of the held item against the present count and cursor
	always_comb begin
		is_ins   = act_q inside {ACT_INSERT, ACT_APPEND};
		eff_cur  = (act_q == ACT_APPEND) ? count_q : cur_q;
		full     = (count_q >= cap_q) || (32'(count_q) >= DEPTH_V);
		ins_ok   = is_ins && !full && (eff_cur <= count_q);
		in_list  = cur_q < count_q;
		last_idx = CNT_W'(count_q - 1'b1);

		sts.is_ins    = is_ins;
		sts.ins_ok    = ins_ok;
		sts.need_up   = ins_ok && (eff_cur != count_q);
		sts.need_read = in_list && ((act_q == ACT_REMOVE) || (act_q == ACT_GET));
		sts.up_done   = (ptr_q == cur_q);
		sts.dn_done   = (act_q == ACT_GET) || (ptr_q == last_idx);
	end

	// status and cursor of each action, and the count for clear, taken at exec
	always_comb begin
		nxt_st  = ST_OK;
		nxt_cur = cur_q;
		nxt_cnt = count_q;
		case (act_q)
			ACT_INSERT: begin
				if (!ins_ok) nxt_st = ST_FULL;
			end
			ACT_APPEND: begin
				nxt_cur = count_q;
				if (!ins_ok) nxt_st = ST_FULL;
			end
			ACT_REMOVE, ACT_GET: begin
				if (!in_list) nxt_st = ST_BAD_POS;
			end
			ACT_START: nxt_cur = '0;
			ACT_END:   nxt_cur = count_q;
			ACT_PREV: begin
				if (cur_q != '0) nxt_cur = CNT_W'(cur_q - 1'b1);
			end
			ACT_NEXT: begin
				if (in_list) nxt_cur = CNT_W'(cur_q + 1'b1);
			end
			ACT_MOVE: begin
				if (pos_q > count_q) nxt_st = ST_BAD_POS;
				else nxt_cur = pos_q;
			end
			ACT_CLEAR: begin
				if (count_q == '0) begin
					nxt_st = ST_EMPTY;
				end else begin
					nxt_cnt = '0;
					nxt_cur = '0;
				end
			end
			default: nxt_st = ST_OK;
		endcase
	end

	// one write port: shifted entry, else the inserted value
	assign ram_we    = wr_q || cmd.put;
	assign ram_waddr = wr_q ? AW'(wptr_q) : AW'(cur_q);
	assign ram_wdata = wr_q ? ram_rdata : val_q;

	alc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(ptr_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			cur_q   <= '0;
			wr_q    <= 1'b0;
			grab_q  <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.exec) begin
				count_q <= nxt_cnt;
				cur_q   <= nxt_cur;
			end
			if (cmd.drain && (act_q == ACT_REMOVE)) count_q <= CNT_W'(count_q - 1'b1);
			if (cmd.put) count_q <= CNT_W'(count_q + 1'b1);
			wr_q   <= cmd.scan_up || (cmd.scan_dn && (ptr_q != cur_q));
			grab_q <= cmd.scan_dn && (ptr_q == cur_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			val_q <= value;
			pos_q <= position;
		end
		if (cmd.exec) begin
			res_st_q <= nxt_st;
			res_rd_q <= '0;
			ptr_q    <= is_ins ? last_idx : cur_q;
		end
		if (cmd.scan_up) begin
			ptr_q  <= CNT_W'(ptr_q - 1'b1);
			wptr_q <= CNT_W'(ptr_q + 1'b1);
		end
		if (cmd.scan_dn) begin
			ptr_q  <= CNT_W'(ptr_q + 1'b1);
			wptr_q <= CNT_W'(ptr_q - 1'b1);
		end
		if (grab_q) res_rd_q <= ram_rdata;
		if (cmd.post) begin
			status_q     <= res_st_q;
			read_value_q <= res_rd_q;
			length_q     <= count_q;
			cursor_q     <= cur_q;
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;
	assign cursor     = cursor_q;

endmodule
`default_nettype wire

[hdl/array_list_with_cursor.sv]
// top level of the array list with cursor
`default_nettype none
// Ordered list of signed 32-bit entries held in a DEPTH-entry ram, with a
// cursor; each input item carries one action (insert, append, remove, start,
// end, previous, next, move-to, get, clear) and gives exactly one result item
// with a status, the removed or read value, and the length and cursor after
// the action. The capacity register (reset 16) caps the length at
// min(capacity, DEPTH) and may be written only while the block is idle.
// One item is in work at a time. Cursor moves, move-to, clear, unknown action
// codes and every action that fails go straight to the result; get reads the
// entry at the cursor, remove also shifts every entry behind the cursor down
// by one, and a successful insert shifts the entries from the cursor to the
// end up by one before it writes the value: the single write port of the
// entry ram moves one entry per cycle. An insert with the cursor at the end
// and every successful append need no shift. A new item is taken as soon as
// the controller is back in idle, while the previous result may still wait in
// the output register. Entries come up undefined and need no clearing pass.
`include "assert_macros.svh"
module array_list_with_cursor import alc_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_data,
	// input items
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [CNT_W-1:0]  position,
	// result items
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [ST_W-1:0]   status,
	output logic      [DATA_W-1:0] read_value,
	output logic      [CNT_W-1:0]  length,
	output logic      [CNT_W-1:0]  cursor
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing of each item
	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entry store, count, cursor and the result register
	alc_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.action     (action),
		.value      (value),
		.position   (position),
		.cmd        (cmd),
		.sts        (sts),
		.status     (status),
		.read_value (read_value),
		.length     (length),
		.cursor     (cursor)
	);

	// the cursor never runs past the end of the list
	`AST_HOLD(a_cursor_in_list, clk, arst_n, !out_valid || (cursor <= length))
	// the list never holds more than the ram can
	`AST_HOLD(a_length_fits, clk, arst_n, !out_valid || (32'(length) <= DEPTH))
	// an accepted item keeps the block busy in the cycle after acceptance
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// shifting and the value write never share the write port
	`AST_HOLD(a_one_writer, clk, arst_n, !(cmd.put && (cmd.scan_up || cmd.scan_dn)))

endmodule
`default_nettype wire
